// File: rtl/mvf_pkg.sv
`default_nettype none
package mvf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int VOICE_W   = 3;
  localparam int TAP_W     = 3;
  localparam int NUM_COEFS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * SAMPLE_W;
  // Eight Q2.30 products need three guard bits.
  localparam int ACC_W     = PROD_W + 3;
  localparam int FRAC_W    = 15;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(16384);
  localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN    = -ACC_W'(32768);

  localparam logic signed [SAMPLE_W-1:0] COEF_ZERO = '0;
  localparam logic signed [SAMPLE_W-1:0] COEF_UNIT = SAMPLE_W'(32767);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/mvf_mac.sv
`default_nettype none
module mvf_mac
  import mvf_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  wire logic signed [SAMPLE_W-1:0] data_i,
  input  wire logic signed [SAMPLE_W-1:0] coef_i,
  output logic                       busy_o,
  output logic signed [SAMPLE_W-1:0] sat_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else if (ctrl_i.clr) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.vld;
      if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= data_i * coef_i;
    end
  end

  assign busy_o = prod_vld_q;

  // Round half up, then clamp to Q1.15.
  always_comb begin
    biased = acc_q + ROUND_BIAS;
    quot   = biased >>> FRAC_W;
    if (quot > SAT_MAX) begin
      sat_o = SAT_MAX[SAMPLE_W-1:0];
    end else if (quot < SAT_MIN) begin
      sat_o = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat_o = quot[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/multi_voice_fir_filter_top.sv
// Multi-voice FIR filter.
// Input channel (in_valid_i/in_ready_o) carries voice_num, a Q1.15 sample and
// a sounding flag. Output channel (out_valid_o/out_ready_i) returns one Q1.15
// sample per input transfer. Coefficients are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write them only while the block is
// idle, which the block itself does not enforce. Every in-range sample is
// stored in its voice's history ring. A sounding voice runs one
// multiply-accumulate per tap through a single shared MAC: history reads,
// one per tap, then a drain of the memory read, product and accumulate
// registers, then the load of the output register. A silent or out-of-range
// voice passes its sample through the finish state into the output register.
// The input side is ready only while the sequencer is idle, so the block takes
// no new input until the last one has been loaded into the output register.
// Reset clears all history valid bits (history reads as zero), every write
// pointer and the coefficients to passthrough (last tap at 32767).
// When the receiver stalls, the result holds in the output register; the
// block still takes the next input and works on it, and then waits with
// that result until the output register frees up.
`default_nettype none
module multi_voice_fir_filter_top
  import mvf_pkg::*;
#(
  parameter int VOICES = 8,
  parameter int TAPS   = 8
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [VOICE_W-1:0]    voice_num_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_in_i,
  input  wire                        sounding_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  input  wire                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [SAMPLE_W-1:0]   cfg_data_i
);

  localparam int N  = VOICES * TAPS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  state_e state_q, state_d;

  logic [TAP_W-1:0]           pos_q, pos_d;
  logic [TAP_W-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]              base_q, base_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       pass_q, pass_d;

  logic signed [SAMPLE_W-1:0] coef_q [NUM_COEFS];
  logic [TAP_W-1:0]           wptr_q [VOICES];
  logic [N-1:0]               hvld_q;
  logic signed [SAMPLE_W-1:0] hist_mem [N];

  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic                       rd_vld_q;
  logic                       rd_en_q;
  logic signed [SAMPLE_W-1:0] rd_coef_q;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_out_q, sample_out_d;

  logic                       in_xfer;
  logic                       in_range;
  logic [VW-1:0]              vidx;
  logic [TAP_W-1:0]           place_raw, place, next_ptr;
  logic [AW-1:0]              base_in, waddr, raddr;
  logic                       hist_we;
  logic                       rd_issue;
  logic                       out_load;
  mac_ctrl_t                  mac_ctrl;
  logic                       mac_busy;
  logic signed [SAMPLE_W-1:0] mac_sat;
  logic signed [SAMPLE_W-1:0] mac_data;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_xfer      = in_valid_i & in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  // Locate the ring slot of the incoming voice.
  assign in_range  = (int'(voice_num_i) < VOICES);
  assign vidx      = VW'(voice_num_i);
  assign place_raw = wptr_q[vidx];
  assign place     = (int'(place_raw) >= TAPS) ? '0 : place_raw;
  assign next_ptr  = ((int'(place) + 1) >= TAPS) ? '0 : place + 1'b1;
  assign base_in   = AW'(int'(voice_num_i) * TAPS);
  assign waddr     = AW'(int'(base_in) + int'(place));
  assign raddr     = AW'(int'(base_q) + int'(pos_q));
  assign hist_we   = in_xfer & in_range;

  // Sequencer: accept, issue one history read per tap, drain, deliver.
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    sample_d     = sample_q;
    pass_d       = pass_q;
    rd_issue     = 1'b0;
    out_load     = 1'b0;
    mac_ctrl.clr = 1'b0;
    mac_ctrl.vld = rd_en_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          sample_d     = sample_in_i;
          base_d       = base_in;
          pos_d        = place;
          cnt_d        = TAP_W'(TAPS - 1);
          pass_d       = !(in_range && sounding_i);
          mac_ctrl.clr = 1'b1;
          state_d      = (in_range && sounding_i) ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        rd_issue = 1'b1;
        pos_d    = (pos_q == '0) ? TAP_W'(TAPS - 1) : pos_q - 1'b1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_en_q && !mac_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    sample_out_d = sample_out_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      sample_out_d = pass_q ? sample_q : mac_sat;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      pass_q      <= 1'b1;
      rd_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
      hvld_q      <= '0;
      for (int i = 0; i < VOICES; i++) begin
        wptr_q[i] <= '0;
      end
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= COEF_ZERO;
      end
      coef_q[NUM_COEFS-1] <= COEF_UNIT;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      pass_q      <= pass_d;
      rd_en_q     <= rd_issue;
      out_valid_q <= out_valid_d;
      if (hist_we) begin
        hvld_q[waddr] <= 1'b1;
        wptr_q[vidx]  <= next_ptr;
      end
      if (cfg_we_i) begin
        coef_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    sample_q     <= sample_d;
    sample_out_q <= sample_out_d;
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[waddr] <= sample_in_i;
    end
    rd_data_q <= hist_mem[raddr];
    rd_vld_q  <= hvld_q[raddr];
    rd_coef_q <= coef_q[cnt_q];
  end

  // Never-written slots read as zero.
  assign mac_data = rd_vld_q ? rd_data_q : '0;

  mvf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .data_i (mac_data),
    .coef_i (rd_coef_q),
    .busy_o (mac_busy),
    .sat_o  (mac_sat)
  );

endmodule
`default_nettype wire

// File: rtl/mvf_checker.sv
`default_nettype none
module mvf_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [15:0] sample_out_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled result changed");

  // Drop ready after a transfer.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // Load a new result only from the busy sequencer.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // Never produce a result in the cycle after a transfer.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early");

endmodule

bind multi_voice_fir_filter_top mvf_checker u_mvf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o)
);
`default_nettype wire
